FILE: sv/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Assertion that is also checked during reset.
`define ASSERT_CLK(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

FILE: sv/utf8t_pkg.sv
// Shared types and constants of the UTF-8 to UTF-16 transcoder.
// No dependencies.
`default_nettype none

package utf8t_pkg;

  // Error codes carried on the result channel
  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_LEAD  = 2'd1,
    ERR_CONT  = 2'd2,
    ERR_POINT = 2'd3
  } err_t;

  // One result beat
  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_of_run;
    err_t        error_kind;
  } result_t;

  // Results handed from the decoder to the output buffer
  typedef struct packed {
    logic    push;
    logic    two;
    result_t r0;
    result_t r1;
  } push_t;

  localparam logic [20:0] CP_MAX      = 21'h10FFFF;
  localparam logic [15:0] SURR_HIGH   = 16'hD800;
  localparam logic [15:0] SURR_LOW    = 16'hDC00;
  localparam logic [15:0] SUPP_OFFSET = 16'h0040;
  // Upper code point bits shared by the whole surrogate range
  localparam logic [9:0]  SURR_TAG    = {5'd0, SURR_HIGH[15:11]};
  localparam logic [7:0]  ASCII_LF    = 8'h0A;
  localparam logic [15:0] UNIT_CR     = 16'h000D;

endpackage

`default_nettype wire

FILE: sv/utf8t_byte_if.sv
// Input channel of the transcoder: one UTF-8 byte per beat.
// No dependencies.
`default_nettype none

interface utf8t_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

FILE: sv/utf8t_unit_if.sv
// Output channel of the transcoder: one UTF-16 code unit per beat.
// No dependencies.
`default_nettype none

interface utf8t_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        last_of_run;
  logic [1:0]  error_kind;

  modport source (output valid, output code_unit, output last_of_run, output error_kind,
                  input ready);
  modport sink (input valid, input code_unit, input last_of_run, input error_kind,
                output ready);
endinterface

`default_nettype wire

FILE: sv/utf8t_in_stage.sv
// Input register of the transcoder.
// Depends on utf8t_byte_if.
`default_nettype none

module utf8t_in_stage (
  input  wire logic   clk,
  input  wire logic   rst,
  utf8t_byte_if.sink  byte_ch,
  input  wire logic   take,
  output logic        held_valid,
  output logic [7:0]  held_byte
);

  logic accept;

  // Free when empty or when the held byte is decoded this cycle
  assign byte_ch.ready = !held_valid || take;
  assign accept        = byte_ch.valid && byte_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_byte <= byte_ch.in_byte;
    end
  end

endmodule

`default_nettype wire

FILE: sv/utf8t_decode.sv
// Decoder state and per-byte decode logic of the transcoder.
// Depends on utf8t_pkg.
`default_nettype none

module utf8t_decode (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          held_valid,
  input  wire logic [7:0]    held_byte,
  input  wire logic          can_push,
  output logic               take,
  output utf8t_pkg::push_t   push
);
  import utf8t_pkg::*;

  logic [1:0]  pending;
  logic [1:0]  pending_next;
  logic [20:0] partial;
  logic [20:0] partial_next;
  logic [20:0] cp_acc;
  logic [1:0]  pending_dec;
  logic [1:0]  num_res;
  result_t     r0;
  result_t     r1;

  assign cp_acc      = {partial[14:0], held_byte[5:0]};
  assign pending_dec = pending - 2'd1;

  // Decode of the held byte against the open sequence
  always_comb begin
    pending_next = pending;
    partial_next = partial;
    num_res      = 2'd0;
    r0           = '0;
    r1           = '0;
    if (pending != 2'd0) begin
      if (!(held_byte inside {[8'h80:8'hBF]})) begin
        num_res      = 2'd1;
        r0           = '{code_unit: 16'd0, last_of_run: 1'b1, error_kind: ERR_CONT};
        pending_next = 2'd0;
        partial_next = '0;
      end else if (pending_dec != 2'd0) begin
        pending_next = pending_dec;
        partial_next = cp_acc;
      end else begin
        pending_next = 2'd0;
        partial_next = '0;
        if (cp_acc > CP_MAX || cp_acc[20:11] == SURR_TAG) begin
          num_res = 2'd1;
          r0      = '{code_unit: 16'd0, last_of_run: 1'b1, error_kind: ERR_POINT};
        end else if (cp_acc[20:16] != 5'd0) begin
          // Supplementary plane: surrogate pair
          num_res = 2'd2;
          r0      = '{code_unit: SURR_HIGH | (16'(cp_acc[20:10]) - SUPP_OFFSET),
                      last_of_run: 1'b0, error_kind: ERR_NONE};
          r1      = '{code_unit: SURR_LOW | {6'd0, cp_acc[9:0]},
                      last_of_run: 1'b1, error_kind: ERR_NONE};
        end else begin
          num_res = 2'd1;
          r0      = '{code_unit: cp_acc[15:0], last_of_run: 1'b1, error_kind: ERR_NONE};
        end
      end
    end else begin
      case (held_byte) inside
        8'b0???_????: begin
          if (held_byte == ASCII_LF) begin
            num_res = 2'd2;
            r0      = '{code_unit: UNIT_CR, last_of_run: 1'b0, error_kind: ERR_NONE};
            r1      = '{code_unit: {8'd0, held_byte}, last_of_run: 1'b1,
                        error_kind: ERR_NONE};
          end else begin
            num_res = 2'd1;
            r0      = '{code_unit: {8'd0, held_byte}, last_of_run: 1'b1,
                        error_kind: ERR_NONE};
          end
        end
        8'b110?_????: begin
          pending_next = 2'd1;
          partial_next = {16'd0, held_byte[4:0]};
        end
        8'b1110_????: begin
          pending_next = 2'd2;
          partial_next = {17'd0, held_byte[3:0]};
        end
        8'b1111_0???: begin
          pending_next = 2'd3;
          partial_next = {18'd0, held_byte[2:0]};
        end
        default: begin
          num_res = 2'd1;
          r0      = '{code_unit: 16'd0, last_of_run: 1'b1, error_kind: ERR_LEAD};
        end
      endcase
    end
  end

  // A byte with no result never waits for the buffer
  assign take      = held_valid && (num_res == 2'd0 || can_push);
  assign push.push = take && num_res != 2'd0;
  assign push.two  = num_res == 2'd2;
  assign push.r0   = r0;
  assign push.r1   = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
      partial <= '0;
    end else if (take) begin
      pending <= pending_next;
      partial <= partial_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/utf8t_out_buf.sv
// Two-entry result register feeding the output channel.
// Depends on utf8t_pkg and utf8t_unit_if.
`default_nettype none

module utf8t_out_buf (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire utf8t_pkg::push_t   push,
  output logic                    can_push,
  utf8t_unit_if.source            unit_ch
);
  import utf8t_pkg::*;

  logic [1:0] count;
  logic [1:0] count_next;
  result_t    head;
  result_t    second;
  logic       pop;

  assign pop      = count != 2'd0 && unit_ch.ready;
  assign can_push = count == 2'd0 || (count == 2'd1 && unit_ch.ready);

  assign unit_ch.valid       = count != 2'd0;
  assign unit_ch.code_unit   = head.code_unit;
  assign unit_ch.last_of_run = head.last_of_run;
  assign unit_ch.error_kind  = head.error_kind;

  // Fill count
  always_comb begin
    if (push.push) begin
      count_next = push.two ? 2'd2 : 2'd1;
    end else if (pop) begin
      count_next = count - 2'd1;
    end else begin
      count_next = count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  // Payload: new pair loads, otherwise second moves to head on a beat
  always_ff @(posedge clk) begin
    if (push.push) begin
      head   <= push.r0;
      second <= push.r1;
    end else if (pop) begin
      head <= second;
    end
  end

endmodule

`default_nettype wire

FILE: sv/utf8_to_utf16_transcoder_top.sv
// UTF-8 to UTF-16 transcoder, top level.
// Depends on utf8t_pkg, utf8t_byte_if, utf8t_unit_if, utf8t_in_stage,
// utf8t_decode and utf8t_out_buf.
//
// Takes one UTF-8 byte per beat on byte_ch and gives UTF-16 code units on
// unit_ch. A byte is taken every cycle while each byte yields at most one
// unit and the sink is ready; a line feed (sent as CR then LF) or a code
// point above U+FFFF (sent as a surrogate pair) yields two units, which
// leave one after the other through the single output port while the next
// byte that yields a unit waits. Lead and middle continuation bytes yield
// no unit. A byte waits in the input register, and its units in the result
// register. Errors (bad lead byte, missing continuation, invalid code
// point) come out as one unit of value zero with error_kind set and
// last_of_run high; the open sequence is dropped.
`default_nettype none

module utf8_to_utf16_transcoder_top (
  input  wire logic     clk,
  input  wire logic     rst,
  utf8t_byte_if.sink    byte_ch,
  utf8t_unit_if.source  unit_ch
);
  import utf8t_pkg::*;

  logic       held_valid;
  logic [7:0] held_byte;
  logic       take;
  logic       can_push;
  push_t      push;

  utf8t_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .byte_ch    (byte_ch),
    .take       (take),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  utf8t_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .held_valid (held_valid),
    .held_byte  (held_byte),
    .can_push   (can_push),
    .take       (take),
    .push       (push)
  );

  utf8t_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .can_push (can_push),
    .unit_ch  (unit_ch)
  );

endmodule

`default_nettype wire

FILE: sv/utf8t_checker.sv
// Port-level checks of the transcoder, bound to the top level.
// Depends on assert_macros.svh and utf8t_pkg.
`default_nettype none
`include "assert_macros.svh"

module utf8t_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        unit_valid,
  input wire logic        unit_ready,
  input wire logic [15:0] code_unit,
  input wire logic        last_of_run,
  input wire logic [1:0]  error_kind
);
  import utf8t_pkg::*;

  // Nothing shown right after reset
  `ASSERT_CLK(a_idle_after_rst, clk, rst |=> !unit_valid)

  // An error beat is a zero unit that ends its run
  `ASSERT_CLK_RST(a_err_shape, clk, rst,
    (unit_valid && error_kind != ERR_NONE) |-> (code_unit == 16'd0 && last_of_run))

  // The first unit of a pair is followed at once by the second
  `ASSERT_CLK_RST(a_pair_follows, clk, rst,
    (unit_valid && unit_ready && !last_of_run) |=> unit_valid)

  // A stalled beat holds its payload
  `ASSERT_CLK_RST(a_stall_hold, clk, rst,
    (unit_valid && !unit_ready) |=> (unit_valid && $stable(code_unit)
      && $stable(last_of_run) && $stable(error_kind)))

endmodule

bind utf8_to_utf16_transcoder_top utf8t_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .unit_valid  (unit_ch.valid),
  .unit_ready  (unit_ch.ready),
  .code_unit   (unit_ch.code_unit),
  .last_of_run (unit_ch.last_of_run),
  .error_kind  (unit_ch.error_kind)
);

`default_nettype wire

FILE: test/utf8_to_utf16_transcoder_top_tb.sv
// Self-checking testbench for utf8_to_utf16_transcoder_top: streams UTF-8 bytes
// in and checks every UTF-16 code unit against an in-bench decoder model.
// Depends on utf8t_pkg, utf8t_byte_if, utf8t_unit_if and the transcoder RTL.
`default_nettype none

module utf8_to_utf16_transcoder_top_tb;
  import utf8t_pkg::*;

  localparam int  HOLD_CYCLES  = 150;      // long receiver hold-off
  localparam int  DRAIN_CYCLES = 8;        // margin after the last expected unit
  localparam int  MAX_REPORTS  = 10;
  localparam real RUN_LIMIT    = 5000000;  // time units

  logic clk;
  logic rst;

  utf8t_byte_if byte_ch ();
  utf8t_unit_if unit_ch ();

  utf8_to_utf16_transcoder_top DUT (
    .clk     (clk),
    .rst     (rst),
    .byte_ch (byte_ch),
    .unit_ch (unit_ch)
  );

  // Decoder model state
  logic [1:0]  cont_left;
  logic [20:0] cp_partial;
  result_t     pending_units[$];

  // Run control and statistics
  bit src_idle_on;
  bit stall_on;
  bit hold_req;
  int bytes_sent;
  int units_seen;
  int mismatches;
  int stalled_cycles;
  int err_seen[4];

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog
  initial begin
    #(RUN_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Queue one expected code unit
  function automatic void expect_unit(input logic [15:0] unit, input logic last,
                                      input err_t kind);
    result_t r;
    r.code_unit   = unit;
    r.last_of_run = last;
    r.error_kind  = kind;
    pending_units.push_back(r);
  endfunction

  // Error beat: open sequence is dropped and decoding restarts
  function automatic void drop_sequence(input err_t kind);
    cont_left  = 2'd0;
    cp_partial = '0;
    expect_unit(16'h0000, 1'b1, kind);
  endfunction

  // Decode one accepted byte into the code units it should produce
  function automatic void transcode_byte(input logic [7:0] b);
    logic [20:0] cp;
    logic [15:0] hi_ofs;
    if (cont_left != 2'd0) begin
      if (b[7:6] != 2'b10) begin
        drop_sequence(ERR_CONT);
        return;
      end
      cp_partial = {cp_partial[14:0], b[5:0]};
      cont_left  = cont_left - 2'd1;
      if (cont_left != 2'd0)
        return;
      cp         = cp_partial;
      cp_partial = '0;
      if (cp > CP_MAX || cp[20:11] == SURR_TAG) begin
        drop_sequence(ERR_POINT);
      end else if (cp > 21'h00FFFF) begin
        // supplementary plane: surrogate pair
        hi_ofs = {5'd0, cp[20:10]} - 16'h0040;
        expect_unit(SURR_HIGH | hi_ofs, 1'b0, ERR_NONE);
        expect_unit(SURR_LOW | {6'd0, cp[9:0]}, 1'b1, ERR_NONE);
      end else begin
        expect_unit(cp[15:0], 1'b1, ERR_NONE);
      end
    end else if (!b[7]) begin
      if (b == ASCII_LF) begin
        expect_unit(UNIT_CR, 1'b0, ERR_NONE);
        expect_unit({8'd0, b}, 1'b1, ERR_NONE);
      end else begin
        expect_unit({8'd0, b}, 1'b1, ERR_NONE);
      end
    end else if (b[7:5] == 3'b110) begin
      cont_left  = 2'd1;
      cp_partial = {16'd0, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      cont_left  = 2'd2;
      cp_partial = {17'd0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      cont_left  = 2'd3;
      cp_partial = {18'd0, b[2:0]};
    end else begin
      drop_sequence(ERR_LEAD);
    end
  endfunction

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Send one byte; called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      byte_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.in_byte <= b;
    do @(posedge clk); while (!byte_ch.ready);
    transcode_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Sender stops until every expected unit has come out
  task automatic pause_until_drained();
    byte_ch.valid <= 1'b0;
    while (pending_units.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // Any byte outside 0x80..0xBF
  function automatic logic [7:0] non_cont_byte();
    int v;
    v = $urandom_range(0, 191);
    return (v < 128) ? 8'(v) : 8'(v + 64);
  endfunction

  // One character: mostly well-formed sequences, some broken ones and noise
  task automatic send_random_char();
    int          kind;
    int          n;
    int          k;
    logic [7:0]  lead;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      send_byte(($urandom_range(0, 7) == 0) ? ASCII_LF : 8'($urandom_range(0, 127)));
    end else if (kind < 55) begin
      send_byte(8'hC0 | 8'($urandom_range(0, 31)));
      send_byte(cont_byte());
    end else if (kind < 72) begin
      // bias toward ED to hit the surrogate range
      lead = ($urandom_range(0, 3) == 0) ? 8'hED : (8'hE0 | 8'($urandom_range(0, 15)));
      send_byte(lead);
      repeat (2) send_byte(cont_byte());
    end else if (kind < 87) begin
      // mostly F0..F4, sometimes F5..F7 beyond U+10FFFF
      lead = ($urandom_range(0, 4) == 0) ? (8'hF0 | 8'($urandom_range(0, 7)))
                                         : (8'hF0 | 8'($urandom_range(0, 4)));
      send_byte(lead);
      repeat (3) send_byte(cont_byte());
    end else if (kind < 95) begin
      // truncated sequence cut off by a non-continuation byte
      n = $urandom_range(1, 3);
      case (n)
        1: lead = 8'hC0 | 8'($urandom_range(0, 31));
        2: lead = 8'hE0 | 8'($urandom_range(0, 15));
        default: lead = 8'hF0 | 8'($urandom_range(0, 7));
      endcase
      k = $urandom_range(0, n - 1);
      send_byte(lead);
      repeat (k) send_byte(cont_byte());
      send_byte(non_cont_byte());
    end else begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Field extremes, LF expansion, each sequence length and each error kind
  task automatic test_directed();
    logic [7:0] seq[] = '{
      8'h00, 8'h7F, 8'h0A,                   // ASCII extremes, LF -> CR LF
      8'hC3, 8'hA9,                          // two-byte sequence
      8'hE2, 8'h82, 8'hAC,                   // three-byte sequence
      8'hF0, 8'h9F, 8'h98, 8'h80,            // surrogate pair
      8'h80,                                 // stray continuation byte
      8'hFF,                                 // byte that can never lead
      8'hC3, 8'h41,                          // missing continuation
      8'hED, 8'hA0, 8'h80,                   // code point in surrogate range
      8'hF4, 8'h90, 8'h80, 8'h80             // code point above U+10FFFF
    };
    src_idle_on = 1'b1;
    stall_on    = 1'b1;
    foreach (seq[i]) send_byte(seq[i]);
    pause_until_drained();
  endtask

  // Random characters, idling and receiver stalls switched on and off in stretches
  task automatic test_random_mix(input int until_bytes);
    int chunk;
    chunk = 0;
    while (bytes_sent < until_bytes) begin
      src_idle_on = (chunk % 3) != 2;
      stall_on    = (chunk % 4) != 3;
      repeat (40) send_random_char();
      chunk++;
    end
    pause_until_drained();
  endtask

  // Receiver holds off long enough to fill the block and stall its input
  task automatic test_backpressure();
    src_idle_on = 1'b0;
    stall_on    = 1'b1;
    hold_req    = 1'b1;
    repeat (20) send_byte(ASCII_LF);
    while (hold_req) send_random_char();
    pause_until_drained();
  endtask

  // Closing stretch at full rate on both sides
  task automatic test_streaming(input int until_bytes);
    src_idle_on = 1'b0;
    stall_on    = 1'b0;
    while (bytes_sent < until_bytes) send_random_char();
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin
    unit_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        unit_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        unit_ch.ready <= 1'b1;
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
        unit_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        unit_ch.ready <= 1'b1;
      end else begin
        unit_ch.ready <= 1'b1;
      end
    end
  end

  // Count stalled input cycles and compare each accepted unit with the oldest expectation
  always @(posedge clk) begin : check_units
    result_t want;
    if (!rst && byte_ch.valid && !byte_ch.ready && !unit_ch.ready)
      stalled_cycles++;
    if (!rst && unit_ch.valid && unit_ch.ready) begin
      units_seen++;
      err_seen[unit_ch.error_kind]++;
      if (pending_units.size() == 0) begin
        note_mismatch($sformatf("unexpected unit %h last %b err %0d",
                                unit_ch.code_unit, unit_ch.last_of_run, unit_ch.error_kind));
      end else begin
        want = pending_units.pop_front();
        if (unit_ch.code_unit !== want.code_unit || unit_ch.last_of_run !== want.last_of_run ||
            unit_ch.error_kind !== want.error_kind)
          note_mismatch($sformatf("expected unit %h last %b err %0d, got %h last %b err %0d",
                                  want.code_unit, want.last_of_run, want.error_kind,
                                  unit_ch.code_unit, unit_ch.last_of_run,
                                  unit_ch.error_kind));
      end
    end
  end

  // Test sequence
  initial begin
    rst             = 1'b1;
    byte_ch.valid   = 1'b0;
    byte_ch.in_byte = 8'h00;
    cont_left       = 2'd0;
    cp_partial      = '0;
    src_idle_on     = 1'b1;
    stall_on        = 1'b1;
    hold_req        = 1'b0;
    bytes_sent      = 0;
    units_seen      = 0;
    mismatches      = 0;
    stalled_cycles  = 0;
    err_seen        = '{0, 0, 0, 0};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_mix(1150);
    test_backpressure();
    test_streaming(1550);

    pause_until_drained();
    if (pending_units.size() != 0)
      note_mismatch($sformatf("%0d units never arrived", pending_units.size()));

    $display("Sent %0d bytes, checked %0d code units; errors lead/cont/point: %0d/%0d/%0d",
             bytes_sent, units_seen, err_seen[ERR_LEAD], err_seen[ERR_CONT],
             err_seen[ERR_POINT]);
    $display("Input held back by a full output path for %0d cycles, %0d mismatches",
             stalled_cycles, mismatches);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire

FILE: utf8_to_utf16_transcoder_top.f
+incdir+sv
sv/utf8t_pkg.sv
sv/utf8t_byte_if.sv
sv/utf8t_unit_if.sv
sv/utf8t_in_stage.sv
sv/utf8t_decode.sv
sv/utf8t_out_buf.sv
sv/utf8_to_utf16_transcoder_top.sv
sv/utf8t_checker.sv
test/utf8_to_utf16_transcoder_top_tb.sv
